// ===== rtl/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Stick smoothing and scaling package
// Shared constants, register indexes and the controller command type.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COUNT_BITS  = 4;
    localparam int COEF_BITS   = 16;
    localparam int CENTER_BITS = 12;
    localparam int OFFSET_BITS = 12;
    localparam int GAIN_SHIFT  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam int NUM_SLOTS  = 6;
    localparam int NUM_SCALED = 4;
    localparam int NUM_OPS    = NUM_SLOTS + NUM_SCALED;
    localparam int OP_BITS    = 4;
    localparam int SLOT_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STICK_GAIN       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THROTTLE_GAIN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_VALUE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_THROTTLE_OFFSET  = 3'd4;

    localparam logic [COEF_BITS-1:0]   RST_SMOOTHING_WEIGHT = 16'd655;
    localparam logic [COEF_BITS-1:0]   RST_STICK_GAIN       = 16'd52429;
    localparam logic [COEF_BITS-1:0]   RST_THROTTLE_GAIN    = 16'd55706;
    localparam logic [CENTER_BITS-1:0] RST_CENTER_VALUE     = 12'd1500;
    localparam logic [OFFSET_BITS-1:0] RST_THROTTLE_OFFSET  = 12'd75;

    // Channel index carried by each filter slot.
    localparam logic [COUNT_BITS-1:0] CHAN_INDEX [NUM_SLOTS] =
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6};

    localparam logic [SLOT_BITS-1:0] SLOT_THROTTLE = 3'd0;

    typedef struct packed {
        logic                latch;
        logic                mul_en;
        logic [OP_BITS-1:0]  mul_op;
        logic                acc_en;
        logic [OP_BITS-1:0]  acc_op;
        logic                load_out;
    } t_cmd;

endpackage

// ===== rtl/stick_smoothing_and_scaling.sv =====
// ----------------------------------------------------------------------------
// Stick smoothing and scaling
// Per-channel exponential smoothing of stick samples with gain about centre.
// ----------------------------------------------------------------------------
// A frame is worked through as ten operations on one shared multiplier, each
// accumulated in turn, and the result is then loaded into the output register.
// A new frame is accepted only after the previous one is loaded out; a finished
// frame waits while the previous result is still held in the output register.
// Synchronous active-low reset clears the filter levels and loads the
// register defaults; no clearing pass is needed.
module stick_smoothing_and_scaling #(
    parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sss_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // channel_count, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    // sample_ch5, sample_ch6
    input  logic [((sss_pkg::COUNT_BITS + 6 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                               s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // roll_out, pitch_out, yaw_out, throttle_out, knob_left_out, knob_right_out
    output logic [((6 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                               m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CB    = sss_pkg::COUNT_BITS;
    localparam int OUT_B = 6 * SAMPLE_BITS;
    localparam int OUT_W = ((OUT_B + 7) / 8) * 8;

    sss_pkg::t_cmd           w_cmd;
    logic [SAMPLE_BITS-1:0]  w_sample [sss_pkg::NUM_SLOTS];
    logic [SAMPLE_BITS-1:0]  w_roll, w_pitch, w_yaw, w_throttle, w_knob_l, w_knob_r;

    always_comb begin
        for (int i = 0; i < sss_pkg::NUM_SLOTS; i++) begin
            w_sample[i] = s_axis_tdata[CB + i * SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    assign m_axis_tdata = OUT_W'({w_knob_r, w_knob_l, w_throttle, w_yaw, w_pitch, w_roll});

    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sss_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_count      (s_axis_tdata[CB-1:0]),
        .i_sample     (w_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_roll       (w_roll),
        .o_pitch      (w_pitch),
        .o_yaw        (w_yaw),
        .o_throttle   (w_throttle),
        .o_knob_left  (w_knob_l),
        .o_knob_right (w_knob_r)
    );

endmodule

// ===== rtl/sss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stick smoothing and scaling controller
// Sequences the shared multiplier over the filter and scaling operations.
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sss_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    localparam logic [sss_pkg::OP_BITS-1:0] LAST_STEP = sss_pkg::OP_BITS'(sss_pkg::NUM_OPS);

    t_state                        r_state, n_state;
    logic [sss_pkg::OP_BITS-1:0]   r_step, n_step;
    logic                          r_out_valid, n_out_valid;
    logic                          w_accept;
    logic                          w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_HOLD;
                end else begin
                    n_step = r_step + sss_pkg::OP_BITS'(1);
                end
            end
            S_HOLD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = w_accept;
        o_cmd.mul_en   = (r_state == S_RUN) && (r_step < LAST_STEP);
        o_cmd.mul_op   = r_step;
        o_cmd.acc_en   = (r_state == S_RUN) && (r_step != '0);
        o_cmd.acc_op   = r_step - sss_pkg::OP_BITS'(1);
        o_cmd.load_out = w_load;
    end

endmodule

// ===== rtl/sss_datapath.sv =====
// ----------------------------------------------------------------------------
// Stick smoothing and scaling datapath
// Frame register, filter levels, configuration, shared multiplier and output.
// ----------------------------------------------------------------------------
module sss_datapath #(
    parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sss_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sss_pkg::t_cmd                       i_cmd,
    input  logic [sss_pkg::COUNT_BITS-1:0]      i_count,
    input  logic [SAMPLE_BITS-1:0]              i_sample [sss_pkg::NUM_SLOTS],
    input  logic                                i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic [SAMPLE_BITS-1:0]              o_roll,
    output logic [SAMPLE_BITS-1:0]              o_pitch,
    output logic [SAMPLE_BITS-1:0]              o_yaw,
    output logic [SAMPLE_BITS-1:0]              o_throttle,
    output logic [SAMPLE_BITS-1:0]              o_knob_left,
    output logic [SAMPLE_BITS-1:0]              o_knob_right
);

    localparam int LW  = SAMPLE_BITS + FRAC_BITS;
    localparam int CW  = sss_pkg::CENTER_BITS + FRAC_BITS;
    localparam int DW  = ((LW > CW) ? LW : CW) + 1;
    localparam int PW  = sss_pkg::COEF_BITS + 1 + DW;
    localparam int VW  = DW + 3;
    localparam int WW  = VW - 1 - FRAC_BITS;
    localparam logic [WW-1:0] SAMPLE_MAX = WW'((1 << SAMPLE_BITS) - 1);
    localparam int NS  = sss_pkg::NUM_SLOTS;
    localparam int SB  = sss_pkg::SLOT_BITS;

    logic [sss_pkg::COUNT_BITS-1:0]  r_count;
    logic [SAMPLE_BITS-1:0]          r_sample [NS];
    logic [LW-1:0]                   r_level  [NS];
    logic [SAMPLE_BITS-1:0]          r_scaled [sss_pkg::NUM_SCALED];
    logic signed [PW-1:0]            r_prod;

    logic [sss_pkg::COEF_BITS-1:0]   r_weight;
    logic [sss_pkg::COEF_BITS-1:0]   r_stick_gain;
    logic [sss_pkg::COEF_BITS-1:0]   r_throttle_gain;
    logic [sss_pkg::CENTER_BITS-1:0] r_center;
    logic [sss_pkg::OFFSET_BITS-1:0] r_offset;

    logic                            w_mul_filt;
    logic [SB-1:0]                   w_mul_slot;
    logic [LW-1:0]                   w_mul_level;
    logic [LW-1:0]                   w_target;
    logic [CW-1:0]                   w_ctr;
    logic [sss_pkg::COEF_BITS-1:0]   w_mul_a;
    logic signed [DW-1:0]            w_mul_b;
    logic signed [PW-1:0]            w_prod;

    logic                            w_acc_filt;
    logic [SB-1:0]                   w_acc_slot;
    logic [LW-1:0]                   w_acc_level;
    logic signed [PW-1:0]            w_shift;
    logic signed [DW:0]              w_step;
    logic [DW:0]                     w_fsum;
    logic                            w_acc_upd;
    logic signed [VW-1:0]            w_v;
    logic [WW-1:0]                   w_whole;
    logic [SAMPLE_BITS-1:0]          w_sat;

    assign w_ctr = {r_center, {FRAC_BITS{1'b0}}};

    always_comb begin
        w_mul_filt = (i_cmd.mul_op < sss_pkg::OP_BITS'(NS));
        if (w_mul_filt) begin
            w_mul_slot = i_cmd.mul_op[SB-1:0];
        end else begin
            w_mul_slot = SB'(i_cmd.mul_op - sss_pkg::OP_BITS'(NS));
        end
        w_mul_level = r_level[w_mul_slot];
        w_target    = {r_sample[w_mul_slot], {FRAC_BITS{1'b0}}};
        if (w_mul_filt) begin
            w_mul_a = r_weight;
            w_mul_b = $signed(DW'(w_target)) - $signed(DW'(w_mul_level));
        end else begin
            if (w_mul_slot == sss_pkg::SLOT_THROTTLE) begin
                w_mul_a = r_throttle_gain;
            end else begin
                w_mul_a = r_stick_gain;
            end
            w_mul_b = $signed(DW'(w_mul_level)) - $signed(DW'(w_ctr));
        end
    end

    assign w_prod = PW'($signed({1'b0, w_mul_a})) * PW'(w_mul_b);

    always_comb begin
        w_acc_filt = (i_cmd.acc_op < sss_pkg::OP_BITS'(NS));
        if (w_acc_filt) begin
            w_acc_slot = i_cmd.acc_op[SB-1:0];
        end else begin
            w_acc_slot = SB'(i_cmd.acc_op - sss_pkg::OP_BITS'(NS));
        end
        w_acc_level = r_level[w_acc_slot];
        w_acc_upd   = (sss_pkg::CHAN_INDEX[w_acc_slot] < r_count);
        w_shift     = r_prod >>> sss_pkg::GAIN_SHIFT;
        w_step      = w_shift[DW:0];
        w_fsum      = (DW + 1)'(w_acc_level) + w_step;
        w_v         = $signed(VW'(w_ctr)) + VW'(w_step);
        if (w_acc_slot == sss_pkg::SLOT_THROTTLE) begin
            w_v = w_v - $signed(VW'({r_offset, {FRAC_BITS{1'b0}}}));
        end
        w_whole = w_v[VW-2:FRAC_BITS];
        if (w_v[VW-1]) begin
            w_sat = '0;
        end else if (w_whole > SAMPLE_MAX) begin
            w_sat = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_whole[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_count  <= i_count;
            r_sample <= i_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en && !w_acc_filt) begin
            r_scaled[w_acc_slot[1:0]] <= w_sat;
        end
        if (i_cmd.load_out) begin
            o_throttle   <= r_scaled[0];
            o_yaw        <= r_scaled[1];
            o_pitch      <= r_scaled[2];
            o_roll       <= r_scaled[3];
            o_knob_left  <= r_level[4][LW-1:FRAC_BITS];
            o_knob_right <= r_level[5][LW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cmd.acc_en && w_acc_filt && w_acc_upd) begin
            r_level[w_acc_slot] <= w_fsum[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight        <= sss_pkg::RST_SMOOTHING_WEIGHT;
            r_stick_gain    <= sss_pkg::RST_STICK_GAIN;
            r_throttle_gain <= sss_pkg::RST_THROTTLE_GAIN;
            r_center        <= sss_pkg::RST_CENTER_VALUE;
            r_offset        <= sss_pkg::RST_THROTTLE_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sss_pkg::REG_SMOOTHING_WEIGHT: r_weight        <= i_cfg_data;
                sss_pkg::REG_STICK_GAIN:       r_stick_gain    <= i_cfg_data;
                sss_pkg::REG_THROTTLE_GAIN:    r_throttle_gain <= i_cfg_data;
                sss_pkg::REG_CENTER_VALUE:
                    r_center <= i_cfg_data[sss_pkg::CENTER_BITS-1:0];
                sss_pkg::REG_THROTTLE_OFFSET:
                    r_offset <= i_cfg_data[sss_pkg::OFFSET_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
